// ----- hdl/i2c_mts_pkg.sv -----
`default_nettype none

package i2c_mts_pkg;

    // Byte engine status codes
    localparam logic [7:0] ST_START  = 8'h08;
    localparam logic [7:0] ST_RSTART = 8'h10;
    localparam logic [7:0] ST_WADDR  = 8'h18;
    localparam logic [7:0] ST_WDATA  = 8'h28;
    localparam logic [7:0] ST_RADDR  = 8'h40;
    localparam logic [7:0] ST_RXACK  = 8'h50;
    localparam logic [7:0] ST_RXNACK = 8'h58;

    // Configuration register indexes
    localparam logic [1:0] CFG_KIND  = 2'd0;
    localparam logic [1:0] CFG_ADDR  = 2'd1;
    localparam logic [1:0] CFG_REG   = 2'd2;
    localparam logic [1:0] CFG_COUNT = 2'd3;

    // Transfer kinds (kind 3 behaves as combined)
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;

    // Outcome codes
    localparam logic [1:0] OUT_BUSY = 2'd0;
    localparam logic [1:0] OUT_DONE = 2'd1;
    localparam logic [1:0] OUT_FAIL = 2'd2;

    // Input mode codes
    localparam logic MODE_BEGIN = 1'b0;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_START  = 8'b0000_0010,
        PH_WADDR  = 8'b0000_0100,
        PH_REGB   = 8'b0000_1000,
        PH_WDATA  = 8'b0001_0000,
        PH_RSTART = 8'b0010_0000,
        PH_RADDR  = 8'b0100_0000,
        PH_RECV   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0] transfer_kind;
        logic [7:0] device_address;
        logic [7:0] register_index;
        logic [7:0] byte_count;
    } t_cfg;

    typedef struct packed {
        logic       mode;
        logic [7:0] status_code;
        logic [7:0] received_byte;
        logic [7:0] next_tx_byte;
    } t_item;

    typedef struct packed {
        logic       drive_start;
        logic       drive_stop;
        logic       ack_next;
        logic       load_tx;
        logic [7:0] tx_byte;
        logic       store_rx;
        logic [7:0] rx_byte;
        logic [1:0] outcome;
        logic [7:0] fail_status;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/i2c_mts_cfg.sv -----
`default_nettype none

module i2c_mts_cfg
    import i2c_mts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_wdata,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.transfer_kind  <= KIND_WRITE;
            r_cfg.device_address <= 8'd0;
            r_cfg.register_index <= 8'd0;
            r_cfg.byte_count     <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KIND:  r_cfg.transfer_kind  <= i_cfg_wdata[1:0];
                CFG_ADDR:  r_cfg.device_address <= i_cfg_wdata;
                CFG_REG:   r_cfg.register_index <= i_cfg_wdata;
                CFG_COUNT: r_cfg.byte_count     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/i2c_mts_fsm.sv -----
`default_nettype none

module i2c_mts_fsm
    import i2c_mts_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_bytes_left;
    logic [7:0] n_bytes_left;
    t_result    res;
    logic       reading;
    logic       combined;
    logic       more;
    logic [7:0] st;

    assign reading  = (i_cfg.transfer_kind == KIND_READ);
    assign combined = i_cfg.transfer_kind[1];
    assign more     = (r_bytes_left > 8'd1);
    assign st       = i_item.status_code;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        res          = '0;
        if (i_item.mode == MODE_BEGIN) begin
            res.drive_start = 1'b1;
            n_phase         = PH_START;
            // zero read count reads one byte
            if (i_cfg.transfer_kind != KIND_WRITE && i_cfg.byte_count == 8'd0) begin
                n_bytes_left = 8'd1;
            end else begin
                n_bytes_left = i_cfg.byte_count;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_START: begin
                    if (st == ST_START) begin
                        res.load_tx = 1'b1;
                        if (reading) begin
                            res.tx_byte = i_cfg.device_address | 8'h01;
                            n_phase     = PH_RADDR;
                        end else begin
                            res.tx_byte = i_cfg.device_address & 8'hFE;
                            n_phase     = PH_WADDR;
                        end
                    end
                end
                PH_WADDR: begin
                    if (st == ST_WADDR) begin
                        res.load_tx = 1'b1;
                        res.tx_byte = i_cfg.register_index;
                        n_phase     = combined ? PH_REGB : PH_WDATA;
                    end
                end
                PH_REGB: begin
                    if (st == ST_WDATA) begin
                        res.drive_start = 1'b1;
                        n_phase         = PH_RSTART;
                    end
                end
                PH_WDATA: begin
                    if (st == ST_WDATA) begin
                        if (r_bytes_left != 8'd0) begin
                            res.load_tx  = 1'b1;
                            res.tx_byte  = i_item.next_tx_byte;
                            n_bytes_left = r_bytes_left - 8'd1;
                        end else begin
                            res.drive_stop = 1'b1;
                            res.outcome    = OUT_DONE;
                            n_phase        = PH_IDLE;
                        end
                    end
                end
                PH_RSTART: begin
                    if (st == ST_RSTART) begin
                        res.load_tx = 1'b1;
                        res.tx_byte = i_cfg.device_address | 8'h01;
                        n_phase     = PH_RADDR;
                    end
                end
                PH_RADDR: begin
                    if (st == ST_RADDR) begin
                        // last byte is NACKed as soon as it is armed
                        res.ack_next = more;
                        n_phase      = PH_RECV;
                    end
                end
                PH_RECV: begin
                    if (more && st == ST_RXACK) begin
                        res.store_rx = 1'b1;
                        res.rx_byte  = i_item.received_byte;
                        n_bytes_left = r_bytes_left - 8'd1;
                        res.ack_next = (r_bytes_left > 8'd2);
                    end else if (!more && st == ST_RXNACK) begin
                        res.store_rx   = 1'b1;
                        res.rx_byte    = i_item.received_byte;
                        n_bytes_left   = 8'd0;
                        res.drive_stop = 1'b1;
                        res.outcome    = OUT_DONE;
                        n_phase        = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            // any status other than the expected one aborts with STOP
            if (r_phase != PH_IDLE && !res.load_tx && !res.drive_start &&
                !res.drive_stop && !res.store_rx && n_phase == r_phase) begin
                res.drive_stop  = 1'b1;
                res.outcome     = OUT_FAIL;
                res.fail_status = st;
                res.ack_next    = 1'b0;
                n_phase         = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
        end
    end

    assign o_result = res;

    a_begin_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.mode == MODE_BEGIN |=> r_phase == PH_START)
        else $error("begin beat did not enter the START phase");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.outcome != OUT_BUSY |=> r_phase == PH_IDLE)
        else $error("finished transfer left the sequencer busy");

    a_store_in_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.store_rx |-> r_phase == PH_RECV)
        else $error("received byte stored outside the receive phase");

endmodule

`default_nettype wire

// ----- hdl/i2c_master_transfer_sequencer_core.sv -----
// I2C master transfer sequencer. A begin beat (mode 0) requests START; every
// later status beat (mode 1) from the byte engine is answered with one result
// beat holding the next command: address, register or data byte to load,
// repeated START, ACK/NACK for the next received byte, or STOP with outcome
// done or failed. One beat is taken every cycle while o_in_stall is low; each
// passes an input register and then a result register, and the result register
// loads only when the output side can advance. Configuration writes
// (kind, address, register, count) must only be made while no beat is in
// flight.
`default_nettype none

module i2c_master_transfer_sequencer_core
    import i2c_mts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_mode,
    input  wire logic [7:0] i_status_code,
    input  wire logic [7:0] i_received_byte,
    input  wire logic [7:0] i_next_tx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_drive_start,
    output logic            o_drive_stop,
    output logic            o_ack_next,
    output logic            o_load_tx,
    output logic [7:0]      o_tx_byte,
    output logic            o_store_rx,
    output logic [7:0]      o_rx_byte,
    output logic [1:0]      o_outcome,
    output logic [7:0]      o_fail_status
);

    t_cfg    cfg;
    t_result result;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;
    logic    step;

    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    i2c_mts_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    i2c_mts_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in.mode          <= i_mode;
            r_in.status_code   <= i_status_code;
            r_in.received_byte <= i_received_byte;
            r_in.next_tx_byte  <= i_next_tx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_start = r_out.drive_start;
    assign o_drive_stop  = r_out.drive_stop;
    assign o_ack_next    = r_out.ack_next;
    assign o_load_tx     = r_out.load_tx;
    assign o_tx_byte     = r_out.tx_byte;
    assign o_store_rx    = r_out.store_rx;
    assign o_rx_byte     = r_out.rx_byte;
    assign o_outcome     = r_out.outcome;
    assign o_fail_status = r_out.fail_status;

    a_end_has_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outcome != OUT_BUSY |-> o_drive_stop)
        else $error("transfer ended without STOP");

    a_stalled_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_in_stall |=> r_in_valid && $stable(r_in))
        else $error("waiting input beat lost while output stalled");

endmodule

`default_nettype wire

// ----- tb/i2c_master_transfer_sequencer_core_tb.sv -----
module i2c_master_transfer_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_mts_pkg::*;

    localparam logic       MODE_EVENT          = ~MODE_BEGIN;
    localparam logic [1:0] KIND_COMBINED_ALIAS = 2'd3;
    localparam int         RAND_ITEMS          = 600;

    typedef struct {
        bit         is_cfg;
        logic [1:0] cfg_idx;
        logic [7:0] cfg_val;
        t_item      it;
        bit         fixed;
        t_result    res;
    } t_stim_row;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic [1:0] i_cfg_index     = '0;
    logic [7:0] i_cfg_wdata     = '0;
    logic       i_in_valid      = 1'b0;
    logic       i_mode          = 1'b0;
    logic [7:0] i_status_code   = '0;
    logic [7:0] i_received_byte = '0;
    logic [7:0] i_next_tx_byte  = '0;
    logic       i_out_stall     = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_drive_start;
    logic       o_drive_stop;
    logic       o_ack_next;
    logic       o_load_tx;
    logic [7:0] o_tx_byte;
    logic       o_store_rx;
    logic [7:0] o_rx_byte;
    logic [1:0] o_outcome;
    logic [7:0] o_fail_status;

    // predictor state and shadow of the register file
    t_cfg       live_cfg;
    t_phase     seq_phase;
    logic [7:0] bytes_togo;
    logic       xfer_busy;

    t_result     pending_cmds[$];
    t_stim_row   directed_rows[$];
    int unsigned mismatches   = 0;
    int unsigned beats_sent   = 0;
    int unsigned cmds_checked = 0;
    int unsigned xfers_done   = 0;
    int unsigned xfers_failed = 0;
    int unsigned cfg_writes   = 0;
    int unsigned burst_left   = 0;
    int unsigned stall_left   = 0;
    logic [1:0]  stall_mode   = 2'd0;

    i2c_master_transfer_sequencer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_status_code   (i_status_code),
        .i_received_byte (i_received_byte),
        .i_next_tx_byte  (i_next_tx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_drive_start   (o_drive_start),
        .o_drive_stop    (o_drive_stop),
        .o_ack_next      (o_ack_next),
        .o_load_tx       (o_load_tx),
        .o_tx_byte       (o_tx_byte),
        .o_store_rx      (o_store_rx),
        .o_rx_byte       (o_rx_byte),
        .o_outcome       (o_outcome),
        .o_fail_status   (o_fail_status)
    );

    always #6 i_clk = ~i_clk;

    // status the engine ought to report next in the current phase
    function automatic logic [7:0] awaited_status();
        case (seq_phase)
            PH_START:  return ST_START;
            PH_WADDR:  return ST_WADDR;
            PH_REGB:   return ST_WDATA;
            PH_WDATA:  return ST_WDATA;
            PH_RSTART: return ST_RSTART;
            PH_RADDR:  return ST_RADDR;
            PH_RECV:   return (bytes_togo > 8'd1) ? ST_RXACK : ST_RXNACK;
            default:   return ST_START;
        endcase
    endfunction

    function automatic t_result cmd(logic start, logic stop, logic [1:0] oc, logic [7:0] fs);
        t_result r;
        r             = '0;
        r.drive_start = start;
        r.drive_stop  = stop;
        r.outcome     = oc;
        r.fail_status = fs;
        return r;
    endfunction

    function automatic t_result sequence_step(input t_item it);
        t_result r;
        logic    reading;
        logic    combined;
        r        = '0;
        reading  = (live_cfg.transfer_kind == KIND_READ);
        combined = live_cfg.transfer_kind[1];
        if (it.mode == MODE_BEGIN) begin
            r.drive_start = 1'b1;
            seq_phase     = PH_START;
            xfer_busy     = 1'b1;
            bytes_togo    = live_cfg.byte_count;
            if (live_cfg.transfer_kind != KIND_WRITE && bytes_togo == 8'd0)
                bytes_togo = 8'd1;
            return r;
        end
        if (!xfer_busy || seq_phase == PH_IDLE) begin
            seq_phase = PH_IDLE;
            xfer_busy = 1'b0;
            return r;
        end
        if (it.status_code != awaited_status()) begin
            r         = cmd(1'b0, 1'b1, OUT_FAIL, it.status_code);
            seq_phase = PH_IDLE;
            xfer_busy = 1'b0;
            return r;
        end
        case (seq_phase)
            PH_START: begin
                r.load_tx = 1'b1;
                if (reading) begin
                    r.tx_byte = live_cfg.device_address | 8'h01;
                    seq_phase = PH_RADDR;
                end else begin
                    r.tx_byte = live_cfg.device_address & 8'hFE;
                    seq_phase = PH_WADDR;
                end
            end
            PH_WADDR: begin
                r.load_tx = 1'b1;
                r.tx_byte = live_cfg.register_index;
                seq_phase = combined ? PH_REGB : PH_WDATA;
            end
            PH_REGB: begin
                r.drive_start = 1'b1;
                seq_phase     = PH_RSTART;
            end
            PH_WDATA: begin
                if (bytes_togo != 8'd0) begin
                    r.load_tx  = 1'b1;
                    r.tx_byte  = it.next_tx_byte;
                    bytes_togo = bytes_togo - 8'd1;
                end else begin
                    r         = cmd(1'b0, 1'b1, OUT_DONE, 8'h00);
                    seq_phase = PH_IDLE;
                    xfer_busy = 1'b0;
                end
            end
            PH_RSTART: begin
                r.load_tx = 1'b1;
                r.tx_byte = live_cfg.device_address | 8'h01;
                seq_phase = PH_RADDR;
            end
            PH_RADDR: begin
                // last byte is NACKed as soon as it is armed
                r.ack_next = (bytes_togo > 8'd1);
                seq_phase  = PH_RECV;
            end
            default: begin
                r.store_rx = 1'b1;
                r.rx_byte  = it.received_byte;
                if (bytes_togo > 8'd1) begin
                    bytes_togo = bytes_togo - 8'd1;
                    r.ack_next = (bytes_togo > 8'd1);
                end else begin
                    bytes_togo    = 8'd0;
                    r.drive_stop  = 1'b1;
                    r.outcome     = OUT_DONE;
                    seq_phase     = PH_IDLE;
                    xfer_busy     = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic string fmt_cmd(t_result r);
        return {$sformatf("start=%0b stop=%0b ack=%0b load=%0b tx=%02h ",
                          r.drive_start, r.drive_stop, r.ack_next, r.load_tx, r.tx_byte),
                $sformatf("store=%0b rx=%02h out=%0d fail=%02h",
                          r.store_rx, r.rx_byte, r.outcome, r.fail_status)};
    endfunction

    // called at a rising edge; returns at the edge the beat was taken (or after its gap)
    task automatic push_beat(input t_item it, input bit fixed, input t_result res);
        int unsigned gap;
        t_result     predicted;
        i_in_valid      <= 1'b1;
        i_mode          <= it.mode;
        i_status_code   <= it.status_code;
        i_received_byte <= it.received_byte;
        i_next_tx_byte  <= it.next_tx_byte;
        do @(negedge i_clk); while (o_in_stall !== 1'b0);
        @(posedge i_clk);
        predicted = sequence_step(it);
        pending_cmds.push_back(fixed ? res : predicted);
        beats_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 10);
            gap        = $urandom_range(1, 7);
        end else begin
            burst_left--;
            gap = 0;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register writes only once everything in flight has come out
    task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_KIND:  live_cfg.transfer_kind  = val[1:0];
            CFG_ADDR:  live_cfg.device_address = val;
            CFG_REG:   live_cfg.register_index = val;
            default:   live_cfg.byte_count     = val;
        endcase
        cfg_writes++;
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [7:0] val);
        t_stim_row row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        directed_rows.push_back(row);
    endtask

    task automatic add_beat(input logic m, input logic [7:0] st, input logic [7:0] rx,
                            input logic [7:0] tx, input bit fixed, input t_result res);
        t_stim_row row;
        row    = '{default: '0};
        row.it = '{mode: m, status_code: st, received_byte: rx, next_tx_byte: tx};
        row.fixed = fixed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    // receiver back-pressure: free-flowing, random, periodic (low two bits of the countdown zero), or heavy
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_left <= $urandom_range(8, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            2'd0:    i_out_stall <= 1'b0;
            2'd1:    i_out_stall <= ($urandom_range(0, 99) < 35);
            2'd2:    i_out_stall <= (stall_left[1:0] == 2'd0);
            default: i_out_stall <= ($urandom_range(0, 99) < 80);
        endcase
    end

    // result beat is taken at the next rising edge; values are settled here
    always @(negedge i_clk) begin
        t_result got;
        t_result want;
        string   bad;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got = '{drive_start: o_drive_start, drive_stop: o_drive_stop,
                    ack_next: o_ack_next, load_tx: o_load_tx, tx_byte: o_tx_byte,
                    store_rx: o_store_rx, rx_byte: o_rx_byte, outcome: o_outcome,
                    fail_status: o_fail_status};
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %s", fmt_cmd(got));
            end else begin
                want = pending_cmds.pop_front();
                cmds_checked++;
                if (want.outcome == OUT_DONE) xfers_done++;
                if (want.outcome == OUT_FAIL) xfers_failed++;
                bad = "";
                if (got.drive_start !== want.drive_start) bad = {bad, " drive_start"};
                if (got.drive_stop  !== want.drive_stop)  bad = {bad, " drive_stop"};
                if (got.ack_next    !== want.ack_next)    bad = {bad, " ack_next"};
                if (got.load_tx     !== want.load_tx)     bad = {bad, " load_tx"};
                if (got.tx_byte     !== want.tx_byte)     bad = {bad, " tx_byte"};
                if (got.store_rx    !== want.store_rx)    bad = {bad, " store_rx"};
                if (got.rx_byte     !== want.rx_byte)     bad = {bad, " rx_byte"};
                if (got.outcome     !== want.outcome)     bad = {bad, " outcome"};
                if (got.fail_status !== want.fail_status) bad = {bad, " fail_status"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on result %0d,%s\n  expected %s\n  actual   %s",
                                 cmds_checked, bad, fmt_cmd(want), fmt_cmd(got));
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_item       it;
        int unsigned n;
        int unsigned roll;
        bit          first_cfg;
        bit          clean;
        logic [7:0]  count;

        live_cfg   = '{transfer_kind: KIND_WRITE, device_address: 8'h00,
                       register_index: 8'h00, byte_count: 8'd1};
        seq_phase  = PH_IDLE;
        bytes_togo = 8'd0;
        xfer_busy  = 1'b0;
        clean      = 1'b1;

        // event with nothing under way
        add_beat(MODE_EVENT, ST_START, 8'h00, 8'h00, 1'b1,
                 cmd(1'b0, 1'b0, OUT_BUSY, 8'h00));
        // write kind, one data byte, address with bit 0 set
        add_cfg(CFG_KIND, {6'd0, KIND_WRITE});
        add_cfg(CFG_ADDR, 8'hFF);
        add_cfg(CFG_REG, 8'hA5);
        add_cfg(CFG_COUNT, 8'd1);
        add_beat(MODE_BEGIN, 8'h00, 8'h00, 8'h00, 1'b1,
                 cmd(1'b1, 1'b0, OUT_BUSY, 8'h00));
        add_beat(MODE_EVENT, ST_START, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_WADDR, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_WDATA, 8'h00, 8'hFF, 1'b0, '0);
        add_beat(MODE_EVENT, ST_WDATA, 8'h00, 8'h00, 1'b1,
                 cmd(1'b0, 1'b1, OUT_DONE, 8'h00));
        // plain read with zero count: one byte, NACKed straight away
        add_cfg(CFG_KIND, {6'd0, KIND_READ});
        add_cfg(CFG_ADDR, 8'h00);
        add_cfg(CFG_COUNT, 8'd0);
        add_beat(MODE_BEGIN, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                 cmd(1'b1, 1'b0, OUT_BUSY, 8'h00));
        add_beat(MODE_EVENT, ST_START, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_RADDR, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_RXNACK, 8'hFF, 8'h00, 1'b0, '0);
        // kind 3 behaves as combined write-then-read
        add_cfg(CFG_KIND, {6'd0, KIND_COMBINED_ALIAS});
        add_cfg(CFG_ADDR, 8'h80);
        add_cfg(CFG_REG, 8'h00);
        add_cfg(CFG_COUNT, 8'd2);
        add_beat(MODE_BEGIN, 8'h00, 8'h00, 8'h00, 1'b1,
                 cmd(1'b1, 1'b0, OUT_BUSY, 8'h00));
        add_beat(MODE_EVENT, ST_START, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_WADDR, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_WDATA, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_RSTART, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_RADDR, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_RXACK, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_RXNACK, 8'h5A, 8'h00, 1'b0, '0);
        // zero write count: STOP right after the register byte
        add_cfg(CFG_KIND, {6'd0, KIND_WRITE});
        add_cfg(CFG_COUNT, 8'd0);
        add_beat(MODE_BEGIN, 8'h00, 8'h00, 8'h00, 1'b1,
                 cmd(1'b1, 1'b0, OUT_BUSY, 8'h00));
        add_beat(MODE_EVENT, ST_START, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_WADDR, 8'h00, 8'h00, 1'b0, '0);
        add_beat(MODE_EVENT, ST_WDATA, 8'h00, 8'h00, 1'b1,
                 cmd(1'b0, 1'b1, OUT_DONE, 8'h00));
        // restart while busy, then a zero status aborts
        add_beat(MODE_BEGIN, 8'h00, 8'h00, 8'h00, 1'b1,
                 cmd(1'b1, 1'b0, OUT_BUSY, 8'h00));
        add_beat(MODE_BEGIN, 8'h00, 8'h00, 8'h00, 1'b1,
                 cmd(1'b1, 1'b0, OUT_BUSY, 8'h00));
        add_beat(MODE_EVENT, 8'h00, 8'h00, 8'h00, 1'b1,
                 cmd(1'b0, 1'b1, OUT_FAIL, 8'h00));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg)
                set_reg(directed_rows[k].cfg_idx, directed_rows[k].cfg_val);
            else
                push_beat(directed_rows[k].it, directed_rows[k].fixed, directed_rows[k].res);
        end

        // mostly clean transfers with random content; some noisy ones
        n         = 0;
        first_cfg = 1'b1;
        while (n < RAND_ITEMS) begin
            if (!xfer_busy && (first_cfg || $urandom_range(0, 2) == 0)) begin
                roll = $urandom_range(0, 99);
                if (first_cfg)      count = 8'hFF;
                else if (roll < 70) count = 8'($urandom_range(0, 3));
                else if (roll < 95) count = 8'($urandom_range(4, 16));
                else                count = 8'($urandom);
                set_reg(CFG_KIND, 8'($urandom));
                set_reg(CFG_ADDR, 8'($urandom));
                set_reg(CFG_REG, 8'($urandom));
                set_reg(CFG_COUNT, count);
                first_cfg = 1'b0;
            end
            it.received_byte = 8'($urandom);
            it.next_tx_byte  = 8'($urandom);
            it.status_code   = 8'($urandom);
            roll = $urandom_range(0, 99);
            if (!xfer_busy) begin
                if (roll < 8) begin
                    it.mode = MODE_EVENT;
                end else begin
                    it.mode = MODE_BEGIN;
                    clean   = (live_cfg.byte_count > 8'd16) || ($urandom_range(0, 9) < 7);
                end
            end else if (!clean && roll < 5) begin
                it.mode = MODE_BEGIN;
            end else if (!clean && roll < 12) begin
                it.mode = MODE_EVENT;
            end else begin
                it.mode        = MODE_EVENT;
                it.status_code = awaited_status();
            end
            // events while idle are ignored by the block and not counted
            if (it.mode == MODE_BEGIN || xfer_busy) n++;
            push_beat(it, 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d beats sent (%0d directed rows), %0d results checked, %0d register writes",
                 beats_sent, directed_rows.size(), cmds_checked, cfg_writes);
        $display("%0d transfers completed, %0d aborted on bad status, %0d mismatches",
                 xfers_done, xfers_failed, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- i2c_master_transfer_sequencer_core.f -----
hdl/i2c_mts_pkg.sv
hdl/i2c_mts_cfg.sv
hdl/i2c_mts_fsm.sv
hdl/i2c_master_transfer_sequencer_core.sv
tb/i2c_master_transfer_sequencer_core_tb.sv
